// ----- src/swrmf_pkg.sv -----
// Shared types and constants of the sliding-window rank/mean filter.
// Used by the front end, the back end and the top level.
`timescale 1ns / 1ps

package swrmf_pkg;

    localparam int MODE_W  = 2;
    localparam int WSIZE_W = 6;
    localparam int CFG_W   = 6;

    localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIM   = 2'd2;

    localparam logic CFG_FILTER_MODE = 1'b0;
    localparam logic CFG_WINDOW_SIZE = 1'b1;

    typedef enum logic [1:0] {
        F_ACC  = 2'b01,
        F_EMIT = 2'b10
    } t_front_state;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_LOAD = 5'b00010,
        B_SUM  = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } t_back_state;

endpackage

// ----- src/swrmf_queue.sv -----
// Two-entry job queue between the front end and the back end.
// Generic width; no package dependency.
`timescale 1ns / 1ps

module swrmf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_rp;
    logic             r_wp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
endmodule

// ----- src/swrmf_front.sv -----
// Front end: accepts samples, tracks the stream position and issues one
// filter job per result. Depends on swrmf_pkg.
`timescale 1ns / 1ps

module swrmf_front #(
    parameter int WINDOW_MAX = 32,
    parameter int SB         = 16,
    parameter int CNT_W      = 6,
    parameter int PW         = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [swrmf_pkg::WSIZE_W-1:0] i_wsize,
    input  logic                         i_valid,
    input  logic [SB-1:0]                i_sample,
    input  logic                         i_fin,
    input  logic                         i_can_take,
    output logic                         o_ready,
    output logic                         o_mem_we,
    output logic [PW-1:0]                o_mem_addr,
    output logic [SB-1:0]                o_mem_data,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [CNT_W-1:0]             o_job_n,
    output logic [PW-1:0]                o_job_head,
    output logic                         o_job_last
);
    import swrmf_pkg::*;

    t_front_state     r_state;
    logic [CNT_W-1:0] r_seen;
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_head;
    logic             r_fin;
    logic             r_has_first;
    logic [CNT_W-1:0] r_n_first;
    logic [CNT_W-1:0] r_trail;
    logic [CNT_W-1:0] r_mid;

    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] mid;
    logic [CNT_W:0]   t1;
    logic [CNT_W:0]   t2;
    logic             pre;
    logic             acc;
    logic [CNT_W-1:0] n_trail;

    always_comb begin
        if (i_wsize == '0) begin
            w = CNT_W'(1);
        end else if (32'(i_wsize) > 32'(WINDOW_MAX)) begin
            w = CNT_W'(WINDOW_MAX);
        end else begin
            w = CNT_W'(i_wsize);
        end
        mid = w >> 1;
        t1  = {1'b0, r_seen} + (CNT_W+1)'(1);
        t2  = {1'b0, r_seen} + (CNT_W+1)'(2);
        pre = (r_seen < mid);
        if (!i_fin || pre) begin
            n_trail = '0;
        end else if (t2 >= {1'b0, w}) begin
            n_trail = w - CNT_W'(1) - mid;
        end else begin
            n_trail = r_seen - mid + CNT_W'(1);
        end
    end

    assign o_ready    = (r_state == F_ACC) && i_can_take;
    assign acc        = i_valid && o_ready;
    assign o_mem_we   = acc;
    assign o_mem_addr = r_wp;
    assign o_mem_data = i_sample;

    always_comb begin
        o_push     = 1'b0;
        o_job_n    = r_n_first;
        o_job_last = r_fin && (r_trail == '0);
        if (r_state == F_EMIT && !i_q_full) begin
            if (r_has_first) begin
                o_push = 1'b1;
            end else if (r_trail != '0) begin
                o_push     = 1'b1;
                o_job_n    = r_trail + r_mid;
                o_job_last = (r_trail == CNT_W'(1));
            end
        end
    end
    assign o_job_head = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_ACC;
            r_seen      <= '0;
            r_wp        <= '0;
            r_has_first <= 1'b0;
            r_trail     <= '0;
        end else begin
            unique case (r_state)
                F_ACC: begin
                    if (acc) begin
                        r_head      <= r_wp;
                        r_wp        <= r_wp + PW'(1);
                        r_fin       <= i_fin;
                        r_mid       <= mid;
                        r_has_first <= pre || (t1 >= {1'b0, w});
                        r_n_first   <= pre ? t1[CNT_W-1:0] : w;
                        r_trail     <= n_trail;
                        if (i_fin) begin
                            r_seen <= '0;
                        end else if (32'(r_seen) < WINDOW_MAX) begin
                            r_seen <= r_seen + CNT_W'(1);
                        end
                        r_state <= F_EMIT;
                    end
                end
                F_EMIT: begin
                    if (!i_q_full) begin
                        if (r_has_first) begin
                            r_has_first <= 1'b0;
                        end else if (r_trail != '0) begin
                            r_trail <= r_trail - CNT_W'(1);
                        end else begin
                            r_state <= F_ACC;
                        end
                    end
                end
                default: r_state <= F_ACC;
            endcase
        end
    end
endmodule

// ----- src/swrmf_back.sv -----
// Back end: holds the sample store, sorts or sums one window per job and
// divides iteratively. Depends on swrmf_pkg.
`timescale 1ns / 1ps

module swrmf_back #(
    parameter int WINDOW_MAX = 32,
    parameter int SB         = 16,
    parameter int CNT_W      = 6,
    parameter int PW         = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [swrmf_pkg::MODE_W-1:0] i_mode,
    input  logic                        i_mem_we,
    input  logic [PW-1:0]               i_mem_addr,
    input  logic [SB-1:0]               i_mem_data,
    input  logic                        i_job_valid,
    input  logic [CNT_W-1:0]            i_job_n,
    input  logic [PW-1:0]               i_job_head,
    input  logic                        i_job_last,
    output logic                        o_pop,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SB-1:0]               o_value,
    output logic                        o_last
);
    import swrmf_pkg::*;

    localparam int SUM_W  = SB + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    t_back_state             r_state;
    logic signed [SB-1:0]    r_mem [2**PW];
    logic signed [SB-1:0]    r_rd_data;
    logic                    r_rd_v;
    logic [CNT_W-1:0]        r_n;
    logic [PW-1:0]           r_head;
    logic                    r_last;
    logic [CNT_W-1:0]        r_issue;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SB-1:0]    r_sorted [WINDOW_MAX];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_acc;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_end;
    logic [CNT_W-1:0]        r_tcnt;
    logic [CNT_W-1:0]        r_div;
    logic [CNT_W:0]          r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic [STEP_W-1:0]       r_step;
    logic                    r_neg;
    logic [SB-1:0]           r_result;

    logic [PW-1:0]           rd_addr;
    logic                    gt [WINDOW_MAX];
    logic [CNT_W-1:0]        sel_idx;
    logic signed [SB-1:0]    sel_val;
    logic [CNT_W+8-1:0]      prod;
    logic [CNT_W-1:0]        trim;
    logic [CNT_W:0]          shifted;
    logic [SUM_W-1:0]        mag;
    logic signed [SUM_W-1:0] div_src;
    logic                    is_trim;
    logic                    is_mean;

    assign is_trim = (i_mode == MODE_TRIM);
    assign is_mean = (i_mode == MODE_MEAN);
    assign rd_addr = r_head - r_issue[PW-1:0];
    assign o_pop   = (r_state == B_IDLE) && i_job_valid;
    assign o_busy  = (r_state != B_IDLE);
    assign prod    = (CNT_W+8)'(i_job_n) * (CNT_W+8)'(205);
    assign trim    = CNT_W'(prod >> 10);
    assign sel_idx = is_trim ? r_idx : (r_n >> 1);
    assign sel_val = r_sorted[sel_idx[PW-1:0]];
    assign shifted = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign div_src = is_trim ? r_acc : r_sum;
    assign mag     = div_src[SUM_W-1] ? SUM_W'(-div_src) : SUM_W'(div_src);

    always_ff @(posedge i_clk) begin
        if (i_mem_we) begin
            r_mem[i_mem_addr] <= i_mem_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        for (int k = 0; k < WINDOW_MAX; k++) begin
            gt[k] = (32'(r_cnt) > k) && (r_sorted[k] > r_rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_LOAD && r_rd_v) begin
            for (int k = 0; k < WINDOW_MAX; k++) begin
                if (k > 0 && gt[k-1]) begin
                    r_sorted[k] <= r_sorted[k-1];
                end else if (gt[k] || 32'(r_cnt) == k) begin
                    r_sorted[k] <= r_rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_rd_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != B_OUT) begin
                o_valid <= 1'b0;
            end
            r_rd_v <= (r_state == B_LOAD) && (r_issue < r_n);
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_n     <= i_job_n;
                        r_head  <= i_job_head;
                        r_last  <= i_job_last;
                        r_issue <= '0;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_acc   <= '0;
                        r_idx   <= trim;
                        r_end   <= i_job_n - trim;
                        r_tcnt  <= i_job_n - (trim << 1);
                        r_state <= B_LOAD;
                    end
                end
                B_LOAD: begin
                    if (r_issue < r_n) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (r_rd_v) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_sum <= r_sum + SUM_W'(r_rd_data);
                        if (r_cnt + CNT_W'(1) == r_n) begin
                            r_state <= B_SUM;
                        end
                    end
                end
                B_SUM: begin
                    if (is_trim && r_idx < r_end) begin
                        r_acc <= r_acc + SUM_W'(sel_val);
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (is_trim || is_mean) begin
                        r_div   <= is_trim ? r_tcnt : r_n;
                        r_neg   <= div_src[SUM_W-1];
                        r_quo   <= mag;
                        r_rem   <= '0;
                        r_step  <= STEP_W'(SUM_W);
                        r_state <= B_DIV;
                    end else begin
                        r_result <= sel_val;
                        r_state  <= B_OUT;
                    end
                end
                B_DIV: begin
                    if (r_step != '0) begin
                        if (shifted >= {1'b0, r_div}) begin
                            r_rem <= shifted - {1'b0, r_div};
                            r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem <= shifted;
                            r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                        end
                        r_step <= r_step - STEP_W'(1);
                    end else begin
                        r_result <= r_neg ? SB'(-r_quo) : SB'(r_quo);
                        r_state  <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_value <= r_result;
                        o_last  <= r_last;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// ----- src/sliding_window_rank_mean_filter.sv -----
// Top level of the sliding-window rank/mean filter: configuration
// registers, front end, job queue and back end. Depends on swrmf_pkg.
`timescale 1ns / 1ps

// Gives one filtered sample per input sample, median, mean or trimmed mean
// of a window of up to WINDOW_MAX samples, with trailing outputs after the
// sample flagged by tlast. A sample is taken when the back end and job
// queue are empty; for each result the back end loads the n-sample window
// through the single store read port while it is insertion sorted, then
// sums the middle n-2*floor(n/5) sorted samples in the trimmed mode and
// runs the bit-serial divider in the mean modes. A result that waits at
// the output holds the back end and so the input.
module sliding_window_rank_mean_filter #(
    parameter int WINDOW_MAX  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [swrmf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample
    input  logic                             s_axis_tlast,  // final_sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // filtered_value
    output logic                             m_axis_tlast   // run_end
);
    import swrmf_pkg::*;

    localparam int DW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int JW    = CNT_W + PW + 1;

    logic [MODE_W-1:0]      r_mode;
    logic [WSIZE_W-1:0]     r_wsize;

    logic                   mem_we;
    logic [PW-1:0]          mem_addr;
    logic [SAMPLE_BITS-1:0] mem_data;
    logic                   push;
    logic                   pop;
    logic [CNT_W-1:0]       f_n;
    logic [PW-1:0]          f_head;
    logic                   f_last;
    logic [JW-1:0]          q_data;
    logic                   q_valid;
    logic                   q_full;
    logic                   q_empty;
    logic                   b_busy;
    logic [SAMPLE_BITS-1:0] b_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MEDIAN;
            r_wsize <= WSIZE_W'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_MODE: r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_WINDOW_SIZE: r_wsize <= i_cfg_data[WSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    swrmf_front #(
        .WINDOW_MAX(WINDOW_MAX), .SB(SAMPLE_BITS), .CNT_W(CNT_W), .PW(PW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wsize    (r_wsize),
        .i_valid    (s_axis_tvalid),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_fin      (s_axis_tlast),
        .i_can_take (q_empty && !b_busy),
        .o_ready    (s_axis_tready),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_addr),
        .o_mem_data (mem_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job_n    (f_n),
        .o_job_head (f_head),
        .o_job_last (f_last)
    );

    swrmf_queue #(.WIDTH(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_n, f_head, f_last}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    swrmf_back #(
        .WINDOW_MAX(WINDOW_MAX), .SB(SAMPLE_BITS), .CNT_W(CNT_W), .PW(PW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_mem_we    (mem_we),
        .i_mem_addr  (mem_addr),
        .i_mem_data  (mem_data),
        .i_job_valid (q_valid),
        .i_job_n     (q_data[JW-1 -: CNT_W]),
        .i_job_head  (q_data[PW:1]),
        .i_job_last  (q_data[0]),
        .o_pop       (pop),
        .o_busy      (b_busy),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_value     (b_value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = DW'(b_value);
endmodule
